[hw/rtl/lpht_pkg.sv]
// types and constants shared by the linear probing hash table modules
`default_nettype none

package lpht_pkg;

  localparam int unsigned KEY_W     = 31;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [CFG_W-1:0]     CFG_SIZE_RST = 9'd256;
  localparam logic [DIV_CNT_W-1:0] DIV_FIRST    = 5'(KEY_W - 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DIV,
    S_HOME,
    S_RD,
    S_CHK,
    S_WIPE,
    S_DONE
  } state_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] slot_index;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    div_step;
    logic    set_home;
    logic    rd;
    logic    advance;
    logic    clr_wr;
    logic    ins_wr;
    logic    del_wr;
    logic    res_load;
    status_e res_status;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    cmd_e cmd;
    logic div_last;
    logic clr_last;
    logic used;
    logic match;
    logic probe_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/lpht_ctrl.sv]
// controller state machine of the linear probing hash table
`default_nettype none

module lpht_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lpht_pkg::cmd_e     in_cmd_i,
  input  lpht_pkg::dp_stat_t stat_i,
  output lpht_pkg::ctrl_cmd_t ctrl_o
);
  import lpht_pkg::*;

  state_e  state_q, state_d;
  status_e res_q, res_d;

  // state and pending result status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      res_q   <= STAT_OK;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    in_ready_o = 1'b0;
    ctrl_o     = '0;
    ctrl_o.res_status = res_q;
    case (state_q)
      S_INIT: begin
        ctrl_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = (in_cmd_i == CMD_CLEAR) ? S_WIPE : S_DIV;
        end
      end
      S_DIV: begin
        ctrl_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_HOME;
      end
      S_HOME: begin
        ctrl_o.set_home = 1'b1;
        state_d         = S_RD;
      end
      S_RD: begin
        ctrl_o.rd = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        if (stat_i.cmd == CMD_INSERT) begin
          if (!stat_i.used) begin
            ctrl_o.ins_wr = 1'b1;
            res_d         = STAT_OK;
            state_d       = S_DONE;
          end else if (stat_i.probe_last) begin
            res_d   = STAT_FULL;
            state_d = S_DONE;
          end else begin
            ctrl_o.advance = 1'b1;
            state_d        = S_RD;
          end
        end else begin
          if (!stat_i.used) begin
            res_d   = STAT_MISSING;
            state_d = S_DONE;
          end else if (stat_i.match) begin
            ctrl_o.del_wr = (stat_i.cmd == CMD_DELETE);
            res_d         = STAT_OK;
            state_d       = S_DONE;
          end else if (stat_i.probe_last) begin
            res_d   = STAT_MISSING;
            state_d = S_DONE;
          end else begin
            ctrl_o.advance = 1'b1;
            state_d        = S_RD;
          end
        end
      end
      S_WIPE: begin
        ctrl_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          res_d   = STAT_OK;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.res_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  // a result is only pushed out of the done state
  a_res_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.res_load |-> state_q == S_DONE)
    else $error("result load outside done state");

  // an item is only taken after the reset sweep has finished
  a_init_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INIT |-> !in_ready_o)
    else $error("item accepted during reset sweep");

  // a probe read is always followed by its check
  a_rd_then_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |=> state_q == S_CHK)
    else $error("probe read not followed by check");

endmodule

`default_nettype wire

[hw/rtl/lpht_dp.sv]
// datapath of the linear probing hash table: divider, probe walk, slot store, result
`default_nettype none

module lpht_dp #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lpht_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  lpht_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lpht_pkg::out_item_t             out_data_o,
  input  lpht_pkg::ctrl_cmd_t             ctrl_i,
  output lpht_pkg::dp_stat_t              stat_o
);
  import lpht_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned NW = IW + 1;
  localparam int unsigned SW = (NW > CFG_W) ? NW : CFG_W;

  logic [CFG_W-1:0]     size_q;
  logic [SW-1:0]        size_ext, size_nz;
  logic [NW-1:0]        n_eff;
  cmd_e                 cmd_q;
  logic [KEY_W-1:0]     key_q;
  logic [NW-1:0]        rem_q;
  logic [NW:0]          rem_sh, rem_sub;
  logic [DIV_CNT_W-1:0] bit_q;
  logic [IW-1:0]        clr_q;
  logic [IW-1:0]        j_q;
  logic [NW-1:0]        j_inc;
  logic [NW-1:0]        cnt_q;
  logic [NW-1:0]        cnt_inc;
  logic                 used_rd_q;
  logic [KEY_W-1:0]     key_rd_q;
  logic                 out_valid_q;
  out_item_t            out_q;
  logic [IW+IDX_W-1:0]  j_ext;
  logic                 used_mem [SLOTS];
  logic [KEY_W-1:0]     key_mem  [SLOTS];

  // effective table size: zero counts as one, saturate at the store depth
  assign size_ext = SW'(size_q);
  assign size_nz  = (size_ext == '0) ? SW'(1) : size_ext;
  assign n_eff    = (size_nz > SW'(SLOTS)) ? NW'(SLOTS) : NW'(size_nz);

  // size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= CFG_SIZE_RST;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= in_data_i.cmd;
      key_q <= in_data_i.key;
    end
  end

  // restoring remainder, one key bit per cycle from the top
  assign rem_sh  = {rem_q, key_q[bit_q]};
  assign rem_sub = rem_sh - {1'b0, n_eff};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q <= '0;
      bit_q <= DIV_FIRST;
    end else if (ctrl_i.div_step) begin
      rem_q <= (rem_sh >= {1'b0, n_eff}) ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
      bit_q <= bit_q - 1'b1;
    end
  end

  // probe position and probe count
  assign j_inc   = {1'b0, j_q} + 1'b1;
  assign cnt_inc = cnt_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.set_home) begin
      j_q   <= rem_q[IW-1:0];
      cnt_q <= '0;
    end else if (ctrl_i.advance) begin
      j_q   <= (j_inc == n_eff) ? '0 : j_inc[IW-1:0];
      cnt_q <= cnt_inc;
    end
  end

  // clearing sweep pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctrl_i.load) begin
      clr_q <= '0;
    end else if (ctrl_i.clr_wr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // occupancy store
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr_wr) begin
      used_mem[clr_q] <= 1'b0;
    end else if (ctrl_i.ins_wr) begin
      used_mem[j_q] <= 1'b1;
    end else if (ctrl_i.del_wr) begin
      used_mem[j_q] <= 1'b0;
    end
    if (ctrl_i.rd) begin
      used_rd_q <= used_mem[j_q];
    end
  end

  // key store
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_wr) begin
      key_mem[j_q] <= key_q;
    end
    if (ctrl_i.rd) begin
      key_rd_q <= key_mem[j_q];
    end
  end

  // result register, freed by an output transfer
  assign j_ext = {{IDX_W{1'b0}}, j_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_load) begin
      out_q.status     <= ctrl_i.res_status;
      out_q.slot_index <= (ctrl_i.res_status == STAT_OK && cmd_q != CMD_CLEAR) ?
                          j_ext[IDX_W-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // status back to the controller
  assign stat_o.cmd        = cmd_q;
  assign stat_o.div_last   = (bit_q == '0);
  assign stat_o.clr_last   = (clr_q == IW'(SLOTS - 1));
  assign stat_o.used       = used_rd_q;
  assign stat_o.match      = (key_rd_q == key_q);
  assign stat_o.probe_last = (cnt_inc == n_eff);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.res_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten");

  // home slot lies inside the table in use
  a_home_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.set_home |=> ({1'b0, j_q} < n_eff))
    else $error("home slot out of range");

  // probe walk never runs past the table size
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.rd |-> (cnt_q < n_eff && {1'b0, j_q} < n_eff))
    else $error("probe past table size");

  // failed commands report slot zero
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != STAT_OK) |-> out_q.slot_index == '0)
    else $error("nonzero slot on failure");

endmodule

`default_nettype wire

[hw/rtl/linear_probe_hash_table.sv]
// top level of the open-addressing hash table with linear probing
//
// channel    direction  handshake                payload
// in         input      in_valid_i / in_ready_o  in_data_i (cmd, key)
// out        output     out_valid_o / out_ready_i out_data_o (status, slot_index)
// cfg        input      cfg_we_i                 cfg_wdata_i (table_size)
//
// insert, delete, search: accept, bit-serial remainder of the key, home slot, then a registered
//   read and a check of the slot store per probe, and at last the result
// clear: accept, a sweep of all SLOTS slots, then the result; one slot per cycle on the store's write port
// after reset a sweep of all SLOTS slots empties the table; no item is taken meanwhile
// a held result stalls only the finish of the next item, which is taken and worked on meanwhile
`default_nettype none

module linear_probe_hash_table #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lpht_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  lpht_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output lpht_pkg::out_item_t        out_data_o
);
  import lpht_pkg::*;

  ctrl_cmd_t ctrl;
  dp_stat_t  stat;

  // sequencer
  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_cmd_i   (in_data_i.cmd),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // divider, probe walk and slot store
  lpht_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire
